// File: hdl/rwlm_pkg.sv
`default_nettype none
package rwlm_pkg;

	// defaults for the top-level parameters
	localparam int QUEUE_DEPTH_DEF = 10;
	localparam int ID_BITS_DEF     = 8;

	// fixed field widths of the words on the channels
	localparam int ID_W   = 8;
	localparam int OP_W   = 2;
	localparam int STAT_W = 3;
	localparam int CNT_W  = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// request kinds
	localparam logic [OP_W-1:0] OP_RD_LOCK   = 2'd0;
	localparam logic [OP_W-1:0] OP_RD_UNLOCK = 2'd1;
	localparam logic [OP_W-1:0] OP_WR_LOCK   = 2'd2;
	localparam logic [OP_W-1:0] OP_WR_UNLOCK = 2'd3;

	// reply status codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_WAIT     = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_RETRY    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_HELD = 3'd4;

	// result kinds
	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_WAKE  = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [ID_W-1:0] thread_id;
	} req_t;

	typedef struct packed {
		logic              kind;
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   target_id;
		logic              last;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;   // capture the accepted request word
		logic exec;       // apply the decision, load the reply
		logic wake_wr;    // load the wake for the waiting writer
		logic drain_step; // load one queued-reader wake, fetch the next
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // output register can take a word this cycle
		logic need_wake;  // current request wakes the waiting writer
		logic need_drain; // current request wakes the reader queue
		logic drain_last; // word in the queue read register is the last
	} dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/rwlm_ram.sv
`default_nettype none
module rwlm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 10,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/rwlm_ctrl.sv
`default_nettype none
module rwlm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire rwlm_pkg::dp_stat_t   stat,
	output rwlm_pkg::ctrl_cmd_t       cmd
);
	import rwlm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_WAKE  = 4'b0100,
		S_DRAIN = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					if (stat.need_wake) begin
						state_d = S_WAKE;
					end else if (stat.need_drain) begin
						state_d = S_DRAIN;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_WAKE: begin
				if (stat.out_free) begin
					cmd.wake_wr = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_DRAIN: begin
				if (stat.out_free) begin
					cmd.drain_step = 1'b1;
					if (stat.drain_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a writer wake never goes out unless an unlock was executed before it, with at most a stall in the wake state between
	a_wake_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wake_wr |-> $past(cmd.exec) || $past(state_q == S_WAKE))
		else $error("writer wake without a preceding unlock");

endmodule
`default_nettype wire

// File: hdl/rwlm_dp.sv
`default_nettype none
module rwlm_dp #(
	parameter int QUEUE_DEPTH = rwlm_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = rwlm_pkg::ID_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rwlm_pkg::req_t       req,
	output rwlm_pkg::rsp_t            rsp,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	input  wire rwlm_pkg::ctrl_cmd_t  cmd,
	output rwlm_pkg::dp_stat_t        stat
);
	import rwlm_pkg::*;

	localparam int IDW   = (ID_BITS < ID_W) ? ID_BITS : ID_W;
	localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILLW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [FILLW-1:0] DEPTH_F = FILLW'(QUEUE_DEPTH);

	// request word
	logic [OP_W-1:0] op_q;
	logic [IDW-1:0]  id_q;

	// lock state
	logic [CNT_W-1:0] cnt_q;
	logic             wr_held_q;
	logic             wr_wait_q;
	logic [IDW-1:0]   wr_id_q;
	logic [FILLW-1:0] fill_q;
	logic [FILLW-1:0] ptr_q;

	// output register
	rsp_t out_q;
	logic out_valid_q;

	// decision for the request in op_q/id_q
	logic [STAT_W-1:0] dec_status;
	logic              dec_last;
	logic              cnt_inc, cnt_dec, wh_set, wh_clr, ww_set, ww_clr, q_push;
	logic              dec_wake, dec_drain;

	logic [IDW-1:0]   q_rdata;
	logic             q_re;
	logic [FILLW-1:0] ptr_nxt;
	logic [AW-1:0]    q_raddr;
	logic             out_load;

	always_comb begin
		dec_status = ST_OK;
		dec_last   = 1'b1;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		wh_set     = 1'b0;
		wh_clr     = 1'b0;
		ww_set     = 1'b0;
		ww_clr     = 1'b0;
		q_push     = 1'b0;
		dec_wake   = 1'b0;
		dec_drain  = 1'b0;
		case (op_q)
			OP_RD_LOCK: begin
				if (!wr_held_q && !wr_wait_q) begin
					if (cnt_q == CNT_MAX) begin
						dec_status = ST_RETRY;
					end else begin
						cnt_inc = 1'b1;
					end
				end else if (fill_q < DEPTH_F) begin
					q_push     = 1'b1;
					dec_status = ST_WAIT;
				end else begin
					dec_status = ST_FULL;
				end
			end
			OP_RD_UNLOCK: begin
				if (cnt_q == '0) begin
					dec_status = ST_NOT_HELD;
				end else begin
					cnt_dec = 1'b1;
					if (cnt_q == CNT_W'(1) && wr_wait_q) begin
						ww_clr   = 1'b1;
						dec_wake = 1'b1;
						dec_last = 1'b0;
					end
				end
			end
			OP_WR_LOCK: begin
				if (cnt_q == '0 && !wr_held_q) begin
					wh_set = 1'b1;
				end else if (!wr_wait_q) begin
					ww_set     = 1'b1;
					dec_status = ST_WAIT;
				end else begin
					dec_status = ST_RETRY;
				end
			end
			OP_WR_UNLOCK: begin
				if (!wr_held_q) begin
					dec_status = ST_NOT_HELD;
				end else begin
					wh_clr = 1'b1;
					if (wr_wait_q) begin
						ww_clr   = 1'b1;
						dec_wake = 1'b1;
						dec_last = 1'b0;
					end else if (fill_q != '0) begin
						dec_drain = 1'b1;
						dec_last  = 1'b0;
					end
				end
			end
			default: begin
				dec_status = ST_NOT_HELD;
			end
		endcase
	end

	// drain: exec fetches entry 0, each step fetches the entry after ptr_q;
	// the last step has nothing left to fetch
	assign ptr_nxt = FILLW'(ptr_q + 1'b1);
	assign q_re    = (cmd.exec && dec_drain) || (cmd.drain_step && !stat.drain_last);
	assign q_raddr = cmd.drain_step ? ptr_nxt[AW-1:0] : '0;

	rwlm_ram #(
		.WIDTH(IDW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.we     (cmd.exec && q_push),
		.waddr  (fill_q[AW-1:0]),
		.wdata  (id_q),
		.re     (q_re),
		.raddr  (q_raddr),
		.rdata_q(q_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q <= req.op;
			id_q <= req.thread_id[IDW-1:0];
		end
		if (cmd.exec && ww_set) begin
			wr_id_q <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			wr_held_q <= 1'b0;
			wr_wait_q <= 1'b0;
			fill_q    <= '0;
			ptr_q     <= '0;
		end else begin
			if (cmd.exec) begin
				if (cnt_inc) cnt_q <= cnt_q + 1'b1;
				if (cnt_dec) cnt_q <= cnt_q - 1'b1;
				if (wh_set) wr_held_q <= 1'b1;
				if (wh_clr) wr_held_q <= 1'b0;
				if (ww_set) wr_wait_q <= 1'b1;
				if (ww_clr) wr_wait_q <= 1'b0;
				if (q_push) fill_q <= fill_q + 1'b1;
				if (dec_drain) ptr_q <= '0;
			end
			if (cmd.drain_step) begin
				if (stat.drain_last) begin
					fill_q <= '0;
				end else begin
					ptr_q <= ptr_nxt;
				end
			end
		end
	end

	// output register
	assign out_load = cmd.exec || cmd.wake_wr || cmd.drain_step;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_q.kind      <= KIND_REPLY;
			out_q.status    <= dec_status;
			out_q.target_id <= ID_W'(id_q);
			out_q.last      <= dec_last;
		end else if (cmd.wake_wr) begin
			out_q.kind      <= KIND_WAKE;
			out_q.status    <= ST_OK;
			out_q.target_id <= ID_W'(wr_id_q);
			out_q.last      <= 1'b1;
		end else if (cmd.drain_step) begin
			out_q.kind      <= KIND_WAKE;
			out_q.status    <= ST_OK;
			out_q.target_id <= ID_W'(q_rdata);
			out_q.last      <= stat.drain_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

	assign stat.out_free   = !out_valid_q || rsp_ready;
	assign stat.need_wake  = dec_wake;
	assign stat.need_drain = dec_drain;
	assign stat.drain_last = (ptr_nxt == fill_q);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_F)
		else $error("reader queue fill beyond depth");

	a_writer_excl: assert property (@(posedge clk) disable iff (!arst_n)
		wr_held_q |-> cnt_q == '0)
		else $error("writer holds the lock while readers are counted");

	a_wait_reason: assert property (@(posedge clk) disable iff (!arst_n)
		wr_wait_q |-> (wr_held_q || cnt_q != '0))
		else $error("writer waits on a free lock");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drain_step |-> (fill_q != '0 && ptr_q < fill_q))
		else $error("queue drain past the fill");

endmodule
`default_nettype wire

// File: hdl/reader_writer_lock_manager_unit.sv
`default_nettype none
// Reader/writer lock manager, writer preference.
//
// req (valid/ready): one word per request, op = read lock, read unlock,
//   write lock or write unlock, plus the requester's thread id.
// rsp (valid/ready): every request gets one reply word (kind = reply);
//   an unlock may follow it with wake words (kind = wake), one per woken
//   thread. The final word caused by a request has last = 1.
// Sequence: a taken request is registered, then executes once the output
//   register is free, loading the reply there, valid from then on. Wakes
//   follow one per cycle while the output register is free; a write unlock
//   that drains the reader queue sends one wake per queued reader.
//   The queued reader ids sit in a RAM with registered read, so the drain
//   runs one entry per cycle through its single read port, stalls aside.
// Stall: the output register holds its word until rsp_ready; the controller
//   waits while the register is occupied and not being emptied. req_ready is
//   high only between requests, independent of the output side.
// Reset: arst_n clears the reader count, the writer flags and the queue
//   fill; queue RAM contents are never cleared (only filled entries are read).
module reader_writer_lock_manager_unit #(
	parameter int QUEUE_DEPTH = rwlm_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = rwlm_pkg::ID_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire rwlm_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output rwlm_pkg::rsp_t       rsp
);
	import rwlm_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencing: accept, execute, then writer wake or reader drain
	rwlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// lock state, reader queue RAM, decision logic, output register
	rwlm_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
`default_nettype wire
